// ===== design/rgbmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbmf_pkg - shared types and constants for the RGB median / weighted mean
// Pixel and window types, shift-line tap layout, divide-by-ten helper.
// ----------------------------------------------------------------------------
package rgbmf_pkg;

  localparam int Chans      = 3;   // channel index: 2 red, 1 green, 0 blue
  localparam int ChanRed    = 2;
  localparam int ChanGreen  = 1;
  localparam int ChanBlue   = 0;
  localparam int ChanW      = 8;
  localparam int WinCells   = 9;
  localparam int MedianRank = 4;   // fifth of nine in ascending order
  localparam int RankW      = $clog2(WinCells + 1);
  localparam int PixCntW    = 4;
  localparam int WinCntW    = 4;
  localparam int GridCells  = 15;
  localparam int FirstResultWin = 12;  // zero-based count of the 13th window
  localparam int ColW       = 2;

  // Stream widths
  localparam int InW  = 24;
  localparam int OutW = 32;

  // Shift line of window results, newest at position 0. The 3x3 block that
  // a result uses always sits at the same positions.
  localparam int LineLen   = 13;
  localparam int TapRow2   = 0;
  localparam int TapRow1   = 5;
  localparam int TapCenter = 6;
  localparam int TapRow0   = 10;

  // Divide by ten: (x * 205) >> 11 is exact for x below 1029.
  localparam int Recip10    = 205;
  localparam int RecipShift = 11;
  localparam int ProdW      = 17;
  localparam int DivW       = 6;   // (2*v)/10 up to 51
  localparam int Div1W      = 5;   // v/10 up to 25
  localparam int SumW       = 8;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef logic [ChanW-1:0]        sample_t;
  typedef sample_t [Chans-1:0]     pixel_t;
  typedef pixel_t [WinCells-1:0]   window_t;
  typedef logic [WinCells-1:0]     mask_t;
  typedef mask_t [Chans-1:0]       sel_t;

  typedef struct packed {
    logic [Chans-1:0][Div1W-1:0] d1;  // v/10
    logic [Chans-1:0][DivW-1:0]  d2;  // (2*v)/10
  } tap_t;

  function automatic logic [DivW-1:0] div10(input logic [ChanW:0] x);
    logic [ProdW-1:0] p;
    p = ProdW'(x) * ProdW'(Recip10);
    return p[RecipShift +: DivW];
  endfunction

endpackage

// ===== design/rgbmf_front.sv =====
// ----------------------------------------------------------------------------
// rgbmf_front - window collector
// Gathers nine pixels into one window and hands it to the queue.
// ----------------------------------------------------------------------------
module rgbmf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rgbmf_pkg::InW-1:0]  s_tdata,   // red, green, blue
  output logic                       win_valid,
  input  logic                       win_ready,
  output rgbmf_pkg::window_t         win_data
);

  localparam logic [rgbmf_pkg::PixCntW-1:0] LastPix =
    rgbmf_pkg::PixCntW'(rgbmf_pkg::WinCells - 1);

  logic [rgbmf_pkg::PixCntW-1:0] pix_cnt;
  rgbmf_pkg::pixel_t             pix_in;
  rgbmf_pkg::pixel_t             held [rgbmf_pkg::WinCells-1];
  logic                          last_pix;
  logic                          accept;

  assign pix_in[rgbmf_pkg::ChanRed]   = s_tdata[7:0];
  assign pix_in[rgbmf_pkg::ChanGreen] = s_tdata[15:8];
  assign pix_in[rgbmf_pkg::ChanBlue]  = s_tdata[23:16];

  assign last_pix  = (pix_cnt == LastPix);
  assign s_tready  = !last_pix || win_ready;
  assign accept    = s_tvalid && s_tready;
  assign win_valid = s_tvalid && last_pix;

  always_comb begin
    for (int i = 0; i < rgbmf_pkg::WinCells - 1; i++) begin
      win_data[i] = held[i];
    end
    win_data[rgbmf_pkg::WinCells-1] = pix_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
    end else if (accept) begin
      pix_cnt <= last_pix ? '0 : pix_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_pix) begin
      held[pix_cnt[$clog2(rgbmf_pkg::WinCells-1)-1:0]] <= pix_in;
    end
  end

endmodule

// ===== design/rgbmf_queue.sv =====
// ----------------------------------------------------------------------------
// rgbmf_queue - window queue
// Short FIFO of whole windows between collector and filter back end.
// ----------------------------------------------------------------------------
module rgbmf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  rgbmf_pkg::window_t push_data,
  output logic               pop_valid,
  input  logic               pop,
  output rgbmf_pkg::window_t pop_data
);

  rgbmf_pkg::window_t             mem [rgbmf_pkg::QueueDepth];
  logic [rgbmf_pkg::QPtrW-1:0]    wr_ptr;
  logic [rgbmf_pkg::QPtrW-1:0]    rd_ptr;
  logic [rgbmf_pkg::QCntW-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  localparam logic [rgbmf_pkg::QPtrW-1:0] LastPtr =
    rgbmf_pkg::QPtrW'(rgbmf_pkg::QueueDepth - 1);

  assign push_ready = (count != rgbmf_pkg::QCntW'(rgbmf_pkg::QueueDepth));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rgbmf_pkg::QCntW'(rgbmf_pkg::QueueDepth))
    else $error("queue count overflow");
`endif

endmodule

// ===== design/rgbmf_back.sv =====
// ----------------------------------------------------------------------------
// rgbmf_back - median and weighted mean back end
// Rank-select median per channel, divide-by-ten shift line, 3x3 sum, output.
// ----------------------------------------------------------------------------
module rgbmf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  rgbmf_pkg::window_t          q_data,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rgbmf_pkg::OutW-1:0]  m_tdata
);

  // stage 1: window and median select masks
  logic                   s1_valid;
  rgbmf_pkg::window_t     s1_win;
  rgbmf_pkg::sel_t        s1_sel;
  rgbmf_pkg::sel_t        sel_next;

  // stage 2: shift line of divided medians
  rgbmf_pkg::tap_t        line [rgbmf_pkg::LineLen];
  rgbmf_pkg::tap_t        tap_new;
  logic [rgbmf_pkg::WinCntW-1:0] win_cnt;
  logic                   s2_valid;
  logic [rgbmf_pkg::ColW-1:0] s2_col;

  // output register
  logic                   out_valid;
  logic [rgbmf_pkg::OutW-1:0] out_data;

  logic                   adv;
  logic [rgbmf_pkg::RankW-1:0] lt_cnt;
  logic [rgbmf_pkg::RankW-1:0] le_cnt;
  rgbmf_pkg::sample_t     med;
  logic [rgbmf_pkg::DivW-1:0] q1;
  logic [rgbmf_pkg::DivW-1:0] q2;
  logic [rgbmf_pkg::Chans-1:0][rgbmf_pkg::SumW-1:0] sum;

  assign adv      = !out_valid || m_tready;
  assign q_pop    = adv && q_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Element i is a median when at most four are below it and at least five
  // are at or below it. Tied winners share one value, so OR-ing them is safe.
  always_comb begin
    for (int ch = 0; ch < rgbmf_pkg::Chans; ch++) begin
      for (int i = 0; i < rgbmf_pkg::WinCells; i++) begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < rgbmf_pkg::WinCells; j++) begin
          lt_cnt = lt_cnt + rgbmf_pkg::RankW'(q_data[j][ch] <  q_data[i][ch]);
          le_cnt = le_cnt + rgbmf_pkg::RankW'(q_data[j][ch] <= q_data[i][ch]);
        end
        sel_next[ch][i] = (lt_cnt <= rgbmf_pkg::RankW'(rgbmf_pkg::MedianRank)) &&
                          (le_cnt >  rgbmf_pkg::RankW'(rgbmf_pkg::MedianRank));
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < rgbmf_pkg::Chans; ch++) begin
      med = '0;
      for (int i = 0; i < rgbmf_pkg::WinCells; i++) begin
        med = med | (s1_sel[ch][i] ? s1_win[i][ch] : '0);
      end
      q1 = rgbmf_pkg::div10({1'b0, med});
      q2 = rgbmf_pkg::div10({med, 1'b0});
      tap_new.d1[ch] = q1[rgbmf_pkg::Div1W-1:0];
      tap_new.d2[ch] = q2;
    end
  end

  // Centre counts (2v)/10, the other eight v/10.
  always_comb begin
    for (int ch = 0; ch < rgbmf_pkg::Chans; ch++) begin
      sum[ch] = rgbmf_pkg::SumW'(line[rgbmf_pkg::TapCenter].d2[ch]) +
                rgbmf_pkg::SumW'(line[rgbmf_pkg::TapRow1].d1[ch]) +
                rgbmf_pkg::SumW'(line[rgbmf_pkg::TapRow1+2].d1[ch]);
      for (int c = 0; c < 3; c++) begin
        sum[ch] = sum[ch] + rgbmf_pkg::SumW'(line[rgbmf_pkg::TapRow0+c].d1[ch]) +
                  rgbmf_pkg::SumW'(line[rgbmf_pkg::TapRow2+c].d1[ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      win_cnt   <= '0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid &&
                   (win_cnt >= rgbmf_pkg::WinCntW'(rgbmf_pkg::FirstResultWin));
      out_valid <= s2_valid;
      if (s1_valid) begin
        win_cnt <= (win_cnt == rgbmf_pkg::WinCntW'(rgbmf_pkg::GridCells - 1)) ?
                   '0 : win_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_win <= q_data;
      s1_sel <= sel_next;
      if (s1_valid) begin
        line[0] <= tap_new;
        for (int p = 1; p < rgbmf_pkg::LineLen; p++) begin
          line[p] <= line[p-1];
        end
        s2_col <= rgbmf_pkg::ColW'(win_cnt -
                  rgbmf_pkg::WinCntW'(rgbmf_pkg::FirstResultWin));
      end
      out_data <= {(rgbmf_pkg::OutW - rgbmf_pkg::ColW - 3 * rgbmf_pkg::SumW)'(0),
                   s2_col,
                   sum[rgbmf_pkg::ChanBlue],
                   sum[rgbmf_pkg::ChanGreen],
                   sum[rgbmf_pkg::ChanRed]};
    end
  end

`ifndef ASSERT_OFF
  a_win_cnt_range: assert property (@(posedge clk) disable iff (rst)
    win_cnt <= rgbmf_pkg::WinCntW'(rgbmf_pkg::GridCells - 1))
    else $error("window count out of range");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid &&
     (win_cnt < rgbmf_pkg::WinCntW'(rgbmf_pkg::FirstResultWin))) |=> !s2_valid)
    else $error("result raised before thirteenth window");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_col <= rgbmf_pkg::ColW'(2)))
    else $error("column offset out of range");
`endif

endmodule

// ===== design/median_then_weighted_mean_rgb_top.sv =====
// ----------------------------------------------------------------------------
// median_then_weighted_mean_rgb_top - 3x3 RGB median with weighted mean
// Per-channel median of each nine-pixel window, then a weighted 3x3 mean
// over a 3x5 grid of window medians after the 13th, 14th and 15th window.
// ----------------------------------------------------------------------------
// Throughput: one pixel item per cycle unless a stalled output fills the
//   queue; at most one result per nine pixels, three results per round of
//   fifteen windows. A result goes from the ninth pixel of its window
//   through queue, median select, shift line and output reg to m_tvalid.
// Reset: synchronous, active high; clears counters, queue and valid flags.
//   Median data is not cleared; every entry read is written first.
module median_then_weighted_mean_rgb_top (
  input  logic                        clk,
  input  logic                        rst,
  // pixel input
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [rgbmf_pkg::InW-1:0]   s_tdata,   // [7:0] red, [15:8] green,
                                                 // [23:16] blue
  // result output
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rgbmf_pkg::OutW-1:0]  m_tdata    // [7:0] mean_red,
                                                 // [15:8] mean_green,
                                                 // [23:16] mean_blue,
                                                 // [25:24] column_offset
);

  // Front collects a window; the queue lets it keep taking pixels while the
  // back end waits on a stalled output.
  logic               win_valid;
  logic               win_ready;
  rgbmf_pkg::window_t win_data;
  logic               q_valid;
  logic               q_pop;
  rgbmf_pkg::window_t q_data;

  rgbmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_data  (win_data)
  );

  rgbmf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (win_valid),
    .push_ready (win_ready),
    .push_data  (win_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // Back end: rank-based median, divide by ten into a 13-deep shift line,
  // fixed taps give the 3x3 block for every result.
  rgbmf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
